// ===== hw/rtl/gdad_pkg.sv =====
// shared types, constants and calendar helpers for the date add-days unit
package gdad_pkg;

  localparam int DAY_W       = 5;
  localparam int MONTH_W     = 4;
  localparam int YEAR_W      = 14;
  // low bits of day_offset that are used, read as two's complement (at most 16)
  localparam int OFFSET_BITS = 16;

  // multiplicative inverse of 25 modulo 2**YEAR_W, and the largest product of a multiple
  localparam logic [YEAR_W-1:0] INV25       = YEAR_W'(7209);
  localparam logic [YEAR_W-1:0] DIV25_LIMIT = YEAR_W'(((1 << YEAR_W) - 1) / 25);

  localparam logic [MONTH_W-1:0] JANUARY  = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] FEBRUARY = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] APRIL    = MONTH_W'(4);
  localparam logic [MONTH_W-1:0] JUNE     = MONTH_W'(6);
  localparam logic [MONTH_W-1:0] SEPTEMBER = MONTH_W'(9);
  localparam logic [MONTH_W-1:0] NOVEMBER = MONTH_W'(11);
  localparam logic [MONTH_W-1:0] DECEMBER = MONTH_W'(12);

  localparam logic [YEAR_W-1:0] YEAR_MIN_RESET = YEAR_W'(1902);
  localparam logic [YEAR_W-1:0] YEAR_MAX_RESET = YEAR_W'(2037);

  typedef enum logic {
    REG_YEAR_MIN = 1'b0,
    REG_YEAR_MAX = 1'b1
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETTLE_START,
    ST_CHECK,
    ST_STEP,
    ST_SETTLE_STEP,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [DAY_W-1:0]   start_day;
    logic [MONTH_W-1:0] start_month;
    logic [YEAR_W-1:0]  start_year;
    logic signed [15:0] day_offset;
  } item_t;

  typedef struct packed {
    logic [DAY_W-1:0]   result_day;
    logic [MONTH_W-1:0] result_month;
    logic [YEAR_W-1:0]  result_year;
    logic               out_of_range;
  } result_t;

  // outcome of one day step
  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
    logic               year_changed;
    logic               wrapped;
  } step_t;

  function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] month,
                                                input logic leap);
    logic [DAY_W-1:0] len;
    len = DAY_W'(31);
    if (month == FEBRUARY) begin
      len = leap ? DAY_W'(29) : DAY_W'(28);
    end else if (month == APRIL || month == JUNE || month == SEPTEMBER ||
                 month == NOVEMBER) begin
      len = DAY_W'(30);
    end
    return len;
  endfunction

endpackage

// ===== hw/rtl/gdad_leap.sv =====
// registered gregorian leap-year test of the current year
module gdad_leap (
  input  logic                       clk,
  input  logic [gdad_pkg::YEAR_W-1:0] year,
  output logic                       leap
);
  import gdad_pkg::*;

  logic [YEAR_W-1:0] prod;
  logic              div25;

  // y is a multiple of 25 exactly when y * inv(25) mod 2**w lands in the low band
  assign prod  = YEAR_W'(year * INV25);
  assign div25 = (prod <= DIV25_LIMIT);

  // by 100 means by 4 and 25, by 400 means by 16 and 25
  always_ff @(posedge clk) begin
    leap <= (year[1:0] == 2'b00) && (!div25 || (year[3:0] == 4'b0000));
  end

endmodule

// ===== hw/rtl/gdad_step.sv =====
// one-day step of a calendar date, forward or backward
module gdad_step (
  input  logic [gdad_pkg::DAY_W-1:0]   day,
  input  logic [gdad_pkg::MONTH_W-1:0] month,
  input  logic [gdad_pkg::YEAR_W-1:0]  year,
  input  logic                         leap,
  input  logic                         backward,
  output gdad_pkg::step_t              step
);
  import gdad_pkg::*;

  always_comb begin
    step.day          = day;
    step.month        = month;
    step.year         = year;
    step.year_changed = 1'b0;
    step.wrapped      = 1'b0;
    if (!backward) begin
      if (day < days_in(month, leap)) begin
        step.day = day + DAY_W'(1);
      end else begin
        step.day = DAY_W'(1);
        if (month < DECEMBER) begin
          step.month = month + MONTH_W'(1);
        end else begin
          step.month        = JANUARY;
          step.year         = year + YEAR_W'(1);
          step.year_changed = 1'b1;
          step.wrapped      = (year == {YEAR_W{1'b1}});
        end
      end
    end else begin
      if (day > DAY_W'(1)) begin
        step.day = day - DAY_W'(1);
      end else if (month > JANUARY) begin
        step.month = month - MONTH_W'(1);
        // leap flag still belongs to this year
        step.day   = days_in(month - MONTH_W'(1), leap);
      end else begin
        step.month        = DECEMBER;
        step.day          = DAY_W'(31);
        step.year         = year - YEAR_W'(1);
        step.year_changed = 1'b1;
        step.wrapped      = (year == '0);
      end
    end
  end

endmodule

// ===== hw/rtl/gregorian_date_add_days_unit.sv =====
// Adds a signed day offset to a calendar date, one day per clock except after a year
// boundary crossed, where the sequencer pauses while the leap flag is re-registered for
// the new year; an invalid start date is echoed unchanged. The single day-step unit
// sets the pace, and the input reopens in the cycle the result appears. The result
// register holds a finished result until it is taken, and a result that is not taken
// holds the sequencer in its last state. A new item is taken only while the sequencer
// is idle. year_min and year_max reset to 1902 and 2037 and are written through the
// cfg port; the user must write them only while idle, and the block itself does not
// enforce this.
module gregorian_date_add_days_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_ready,
  input  gdad_pkg::item_t             item,
  output logic                        result_valid,
  input  logic                        result_ready,
  output gdad_pkg::result_t           result,
  input  logic                        cfg_we,
  input  gdad_pkg::reg_index_t        cfg_index,
  input  logic [gdad_pkg::YEAR_W-1:0] cfg_data
);
  import gdad_pkg::*;

  state_t                 state, state_next;
  logic [DAY_W-1:0]       day, day_next;
  logic [MONTH_W-1:0]     month, month_next;
  logic [YEAR_W-1:0]      year, year_next;
  logic [OFFSET_BITS-1:0] count, count_next;
  logic                   backward, backward_next;
  logic                   bad, bad_next;
  logic [YEAR_W-1:0]      year_min, year_max;
  result_t                result_next;
  logic                   result_valid_next;
  logic                   leap;
  step_t                  step;
  logic [OFFSET_BITS-1:0] raw;
  logic                   raw_neg;

  gdad_leap u_leap (
    .clk  (clk),
    .year (year),
    .leap (leap)
  );

  gdad_step u_step (
    .day      (day),
    .month    (month),
    .year     (year),
    .leap     (leap),
    .backward (backward),
    .step     (step)
  );

  assign raw        = item.day_offset[OFFSET_BITS-1:0];
  assign raw_neg    = raw[OFFSET_BITS-1];
  assign item_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      year_min <= YEAR_MIN_RESET;
      year_max <= YEAR_MAX_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_YEAR_MIN: year_min <= cfg_data;
        REG_YEAR_MAX: year_max <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    day      <= day_next;
    month    <= month_next;
    year     <= year_next;
    count    <= count_next;
    backward <= backward_next;
    bad      <= bad_next;
    result   <= result_next;
  end

  always_comb begin
    state_next        = state;
    day_next          = day;
    month_next        = month;
    year_next         = year;
    count_next        = count;
    backward_next     = backward;
    bad_next          = bad;
    result_next       = result;
    result_valid_next = result_valid && !result_ready;
    unique case (state)
      ST_IDLE: begin
        if (item_valid) begin
          day_next      = item.start_day;
          month_next    = item.start_month;
          year_next     = item.start_year;
          backward_next = raw_neg;
          count_next    = raw_neg ? (~raw + OFFSET_BITS'(1)) : raw;
          bad_next      = 1'b0;
          state_next    = ST_SETTLE_START;
        end
      end
      ST_SETTLE_START: begin
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        // an invalid start date is echoed untouched
        if (month == '0 || month > DECEMBER || day == '0 ||
            day > days_in(month, leap)) begin
          bad_next   = 1'b1;
          state_next = ST_FINISH;
        end else begin
          state_next = ST_STEP;
        end
      end
      ST_STEP: begin
        if (count == '0) begin
          state_next = ST_FINISH;
        end else begin
          day_next   = step.day;
          month_next = step.month;
          year_next  = step.year;
          count_next = count - OFFSET_BITS'(1);
          bad_next   = bad || step.wrapped;
          if (step.year_changed) begin
            state_next = ST_SETTLE_STEP;
          end
        end
      end
      ST_SETTLE_STEP: begin
        state_next = ST_STEP;
      end
      ST_FINISH: begin
        if (!result_valid || result_ready) begin
          result_next.result_day   = day;
          result_next.result_month = month;
          result_next.result_year  = year;
          result_next.out_of_range = bad || (year < year_min) || (year > year_max);
          result_valid_next        = 1'b1;
          state_next               = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/gdad_checker.sv =====
// port-level checks on the date add-days unit, bound to the top level
module gdad_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_ready,
  input logic              result_valid,
  input logic              result_ready,
  input gdad_pkg::result_t result
);
  import gdad_pkg::*;

  // a result beat waits unchanged until it is taken
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result beat changed or dropped while stalled");

  // one item in flight: taking an item closes the input side
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("second item taken while one is in flight");

  // a result follows directly on the previous one only as the sequencer finishes
  a_no_double_result: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_ready |=> !result_valid || item_ready)
    else $error("result shown without a new item");

  // a good date has a real month and day
  a_good_date: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.out_of_range |->
      result.result_month != '0 && result.result_month <= DECEMBER &&
      result.result_day != '0 &&
      result.result_day <= days_in(result.result_month, 1'b1))
    else $error("in-range result with an impossible date");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind gregorian_date_add_days_unit gdad_checker u_gdad_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);
